### rtl/kmrc_pkg.sv
// ============================================================================
// kmrc_pkg: shared types and constants for the k-way merge rank compressor
// Holds the payload structs, the operation codes and the status codes.
// ============================================================================
package kmrc_pkg;

    localparam int MaxRowsDefault    = 16;
    localparam int MaxEntriesDefault = 1024;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_RUN      = 3'd1,
        OP_READ_DST = 3'd2,
        OP_READ_ENT = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] entry_value;
        logic        row_end;
        logic        excluded;
        logic [9:0]  position;
    } in_item_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic [10:0] distinct_count;
        logic [1:0]  status;
    } out_item_t;

endpackage

### rtl/kway_merge_rank_compress.sv
// ============================================================================
// kway_merge_rank_compress: k-way merge with dedup and coordinate compression
// Loads rows of values, merges them into a distinct value store and rewrites
// every entry, except each row's leading excluded entries, with its dense rank.
// ============================================================================
// Each transfer on the input channel produces exactly one result transfer.
// Loads, reads, clears and unused codes pass through S_IDLE, which takes the
// command, S_READ, for the synchronous read of the entry or distinct memory,
// and S_RESP, which places the result in the output register. A run command
// is sequenced by a controller around the single-ported entry memory. It
// first sets up every row: it fetches the row limit, reads and checks each
// leading excluded entry that is skipped, then tests the first kept entry and
// stores the row cursor. It then merges: each merged entry costs a full pass
// over every set-up row, with a synchronous read of each row head and a
// compare, followed by a write of its rank. A last pass finds every row
// exhausted before the result is sent. The row heads are kept in registers;
// the 64-bit values live in the entry and distinct memories.
module kway_merge_rank_compress #(
    parameter int MAX_ROWS    = kmrc_pkg::MaxRowsDefault,
    parameter int MAX_ENTRIES = kmrc_pkg::MaxEntriesDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kmrc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kmrc_pkg::out_item_t out_data
);
    import kmrc_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NW = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_RESP, S_SETUP, S_SKIP_RD, S_SKIP_CHK,
        S_SCAN_RD, S_SCAN_CHK, S_FIN_RD, S_FIN_CHK, S_WRITE, S_OUT
    } state_t;

    // Memories.
    logic [63:0] entry_mem [MAX_ENTRIES];
    logic        excl_mem  [MAX_ENTRIES];
    logic [63:0] dist_mem  [MAX_ENTRIES];
    logic [CW-1:0] limit_mem [MAX_ROWS];

    // Memory ports.
    logic          e_we, e_re, x_we, d_we;
    logic [AW-1:0] e_addr, d_waddr, d_raddr;
    logic [63:0]   e_wdata, e_rdata, d_wdata, d_rdata;
    logic          x_wdata, x_rdata;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            entry_mem[e_addr] <= e_wdata;
        end
        if (x_we)
        begin
            excl_mem[e_addr] <= x_wdata;
        end
        if (e_re)
        begin
            e_rdata <= entry_mem[e_addr];
            x_rdata <= excl_mem[e_addr];
        end
        if (d_we)
        begin
            dist_mem[d_waddr] <= d_wdata;
        end
        d_rdata <= dist_mem[d_raddr];
    end

    // Control and row state.
    state_t        state_reg;
    logic [CW-1:0] entries_reg;
    logic [NW-1:0] rows_reg;
    logic [CW-1:0] total_reg;
    logic [NW-1:0] nrows_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] start_reg, h_reg, end_reg;
    logic [CW-1:0] head_reg [MAX_ROWS];
    logic [CW-1:0] ends_reg [MAX_ROWS];
    logic          found_reg;
    logic [RW-1:0] best_reg;
    logic [63:0]   bestv_reg, lastv_reg;
    logic [2:0]    op_reg;
    logic [AW-1:0] pos_reg;
    logic          range_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    logic          pend_open;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    wire accept = in_valid && in_ready;
    wire full   = (entries_reg >= CW'(MAX_ENTRIES)) || (rows_reg >= NW'(MAX_ROWS));
    wire [31:0]   pos_ext = 32'(in_data.position);
    wire [CW-1:0] cur_limit = limit_mem[r_reg];
    wire [CW-1:0] clamp_hi = (cur_limit > entries_reg) ? entries_reg : cur_limit;
    wire [CW-1:0] row_end_c = (clamp_hi < start_reg) ? start_reg : clamp_hi;
    wire          r_last = (NW'(r_reg) + 1'b1) >= nrows_reg;
    wire          r_live = head_reg[r_reg] < ends_reg[r_reg];
    wire [CW-1:0] inc_total = total_reg + 1'b1;
    wire          dst_bad = !(pos_ext < 32'(total_reg) && pos_ext < 32'(MAX_ENTRIES));
    wire          ent_bad = !(pos_ext < 32'(entries_reg) && pos_ext < 32'(MAX_ENTRIES));

    always_comb
    begin
        e_we = 1'b0; x_we = 1'b0; e_re = 1'b0; d_we = 1'b0;
        e_addr = pos_reg; e_wdata = in_data.entry_value; x_wdata = in_data.excluded;
        d_waddr = total_reg[AW-1:0]; d_wdata = bestv_reg; d_raddr = pos_reg;
        pend_open = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.op == OP_LOAD && !full)
                begin
                    e_we = 1'b1; x_we = 1'b1; e_addr = entries_reg[AW-1:0];
                end
            end
            S_READ:
            begin
                e_re = 1'b1;
            end
            S_SKIP_RD:
            begin
                e_re = 1'b1; e_addr = h_reg[AW-1:0];
            end
            S_SCAN_RD:
            begin
                e_re = 1'b1; e_addr = head_reg[r_reg][AW-1:0];
            end
            S_WRITE:
            begin
                e_we = 1'b1; e_addr = head_reg[best_reg][AW-1:0];
                pend_open = (total_reg == '0) || (bestv_reg != lastv_reg);
                d_we = pend_open && (total_reg < CW'(MAX_ENTRIES));
                e_wdata = d_we ? 64'(total_reg) : 64'(total_reg - 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && in_data.op == OP_LOAD && !full
            && in_data.row_end)
        begin
            limit_mem[rows_reg[RW-1:0]] <= entries_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= '0;
            rows_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            nrows_reg     <= '0;
            r_reg         <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= in_data.op;
                        pos_reg   <= AW'(in_data.position);
                        out_reg.read_value <= '0;
                        out_reg.status     <= (in_data.op == OP_LOAD && full)
                            ? ST_FULL : ST_OK;
                        state_reg <= (in_data.op == OP_RUN) ? S_SETUP : S_READ;
                        range_reg <= ((in_data.op == OP_READ_DST) && dst_bad)
                            || ((in_data.op == OP_READ_ENT) && ent_bad);
                        case (in_data.op)
                            OP_LOAD:
                            begin
                                if (!full)
                                begin
                                    entries_reg <= entries_reg + 1'b1;
                                    if (in_data.row_end)
                                    begin
                                        rows_reg <= rows_reg + 1'b1;
                                    end
                                end
                            end
                            OP_RUN:
                            begin
                                total_reg <= '0;
                                nrows_reg <= '0;
                                r_reg     <= '0;
                                start_reg <= '0;
                            end
                            OP_CLEAR:
                            begin
                                entries_reg <= '0;
                                rows_reg    <= '0;
                                total_reg   <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (range_reg)
                    begin
                        out_reg.status <= ST_RANGE;
                    end
                    else if (op_reg == OP_READ_DST)
                    begin
                        out_reg.read_value <= d_rdata;
                    end
                    else if (op_reg == OP_READ_ENT)
                    begin
                        out_reg.read_value <= e_rdata;
                    end
                    out_reg.distinct_count <= 11'(total_reg);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                // Row setup: closed rows first, then the open tail row.
                S_SETUP:
                begin
                    if (NW'(r_reg) < rows_reg && nrows_reg < NW'(MAX_ROWS))
                    begin
                        end_reg   <= row_end_c;
                        h_reg     <= start_reg;
                        state_reg <= S_SKIP_RD;
                    end
                    else if (start_reg < entries_reg && nrows_reg < NW'(MAX_ROWS))
                    begin
                        end_reg   <= entries_reg;
                        h_reg     <= start_reg;
                        state_reg <= S_SKIP_RD;
                    end
                    else
                    begin
                        r_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (nrows_reg == '0) ? S_OUT : S_SCAN_RD;
                    end
                end
                S_SKIP_RD:
                begin
                    if (h_reg < end_reg)
                    begin
                        state_reg <= S_SKIP_CHK;
                    end
                    else
                    begin
                        state_reg <= S_FIN_RD;
                    end
                end
                S_SKIP_CHK:
                begin
                    if (x_rdata)
                    begin
                        h_reg     <= h_reg + 1'b1;
                        state_reg <= S_SKIP_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIN_RD;
                    end
                end
                S_FIN_RD:
                begin
                    head_reg[nrows_reg[RW-1:0]] <= h_reg;
                    ends_reg[nrows_reg[RW-1:0]] <= end_reg;
                    nrows_reg <= nrows_reg + 1'b1;
                    start_reg <= end_reg;
                    if (NW'(r_reg) < rows_reg)
                    begin
                        r_reg <= r_reg + 1'b1;
                    end
                    state_reg <= (NW'(r_reg) + 1'b1 >= NW'(MAX_ROWS)
                        && NW'(r_reg) < rows_reg) ? S_FIN_CHK : S_SETUP;
                end
                S_FIN_CHK:
                begin
                    // The row table is full, so no open tail row can be added.
                    r_reg     <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_SCAN_RD;
                end
                // Merge: one pass over the row heads per output entry.
                S_SCAN_RD:
                begin
                    state_reg <= r_live ? S_SCAN_CHK : S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (r_live && (!found_reg || e_rdata < bestv_reg))
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= r_reg;
                        bestv_reg <= e_rdata;
                    end
                    if (r_last)
                    begin
                        r_reg <= '0;
                        state_reg <= (found_reg || r_live) ? S_WRITE : S_OUT;
                    end
                    else
                    begin
                        r_reg <= r_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_WRITE:
                begin
                    if (pend_open && total_reg < CW'(MAX_ENTRIES))
                    begin
                        total_reg <= inc_total;
                        lastv_reg <= bestv_reg;
                    end
                    head_reg[best_reg] <= head_reg[best_reg] + 1'b1;
                    found_reg <= 1'b0;
                    state_reg <= S_SCAN_RD;
                end
                S_OUT:
                begin
                    out_reg.distinct_count <= 11'(total_reg);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        entries_reg <= CW'(MAX_ENTRIES))
        else $error("entry count passed capacity");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= entries_reg || state_reg == S_IDLE)
        else $error("distinct total exceeds entries during merge");
    a_result_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP || state_reg == S_OUT) |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule
